FILE: rtl/core/lmrs_pkg.sv
// Shared types and constants for the LED matrix row scan shifter.
// No dependencies; imported by every other file in rtl/core.
package lmrs_pkg;

	localparam int COLUMNS = 16;
	localparam int ROWS    = 7;
	localparam int BYTE_W  = 8;
	localparam int ROW_W   = 3;

	localparam int COL_W  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
	localparam int CNT_W  = $clog2(COLUMNS + 1);
	localparam int PH_W   = $clog2(2 * COLUMNS + 3);

	// phase codes of one tick: 2*COLUMNS shift phases, then strobes
	localparam logic [PH_W-1:0] PH_STROBE = PH_W'(2 * COLUMNS);
	localparam logic [PH_W-1:0] PH_LAST0  = PH_W'(2 * COLUMNS + 2);
	localparam logic [PH_W-1:0] PH_LASTN  = PH_W'(2 * COLUMNS + 1);

	localparam int CMD_DEPTH = 2;
	localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
	localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	typedef logic [COLUMNS-1:0][BYTE_W-1:0] frame_t;

	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic             copy;
	} tick_cmd_t;

	typedef struct packed {
		logic shift_clock;
		logic shift_data;
		logic load_strobe;
		logic row_reset;
		logic last;
	} pin_word_t;

	typedef enum logic {
		BK_IDLE,
		BK_RUN
	} back_state_t;

endpackage

FILE: rtl/core/lmrs_if.sv
// Valid/ready channel interfaces: host words in, pin phase words out.
// Depends on lmrs_pkg.
interface lmrs_in_if import lmrs_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              kind;
	logic [BYTE_W-1:0] column_byte;

	modport source (output valid, output kind, output column_byte, input ready);
	modport sink   (input valid, input kind, input column_byte, output ready);
endinterface

interface lmrs_out_if;
	logic valid;
	logic ready;
	logic shift_clock;
	logic shift_data;
	logic load_strobe;
	logic row_reset;
	logic last;

	modport source (output valid, output shift_clock, output shift_data,
		output load_strobe, output row_reset, output last, input ready);
	modport sink   (input valid, input shift_clock, input shift_data,
		input load_strobe, input row_reset, input last, output ready);
endinterface

FILE: rtl/core/led_matrix_row_scan_shifter.sv
// Top level of the LED matrix row scan shifter: front, command queue, back.
// Depends on lmrs_pkg, lmrs_if, lmrs_front, lmrs_cmd_fifo, lmrs_back.
//
//  port   dir  modport  contents
//  host   in   sink     kind, column_byte (data byte or refresh tick)
//  pins   out  source   shift_clock, shift_data, load_strobe, row_reset, last
//
// A tick yields 2*COLUMNS+3 phase words on row 0 and 2*COLUMNS+2 on other rows,
// one per cycle from the back sequencer while pins.ready does not stall it; the
// back pops the command before the first phase word.
// arst_n clears the display frame, counters, row and queue; staging holds junk.
// Ticks queue up to two deep while the back is busy; data bytes stall while a
// frame copy waits in the queue. The pin output register stalls on pins.ready.
module led_matrix_row_scan_shifter import lmrs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	lmrs_in_if.sink     host,
	lmrs_out_if.source  pins
);

	logic      f_valid, f_ready;
	tick_cmd_t f_cmd;
	logic      b_valid, b_ready;
	tick_cmd_t b_cmd;
	logic      copy_done;
	frame_t    staging;

	// front: staging frame, pending flag and row tracking
	lmrs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.host      (host),
		.cmd_valid (f_valid),
		.cmd       (f_cmd),
		.cmd_ready (f_ready),
		.copy_done (copy_done),
		.staging   (staging)
	);

	// tick command queue decouples the two sides
	lmrs_cmd_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_cmd   (f_cmd),
		.push_ready (f_ready),
		.pop_valid  (b_valid),
		.pop_cmd    (b_cmd),
		.pop_ready  (b_ready)
	);

	// back: display frame copy at pop, then the phase sequence
	lmrs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (b_valid),
		.cmd       (b_cmd),
		.cmd_ready (b_ready),
		.copy_done (copy_done),
		.staging   (staging),
		.pins      (pins)
	);

endmodule

FILE: rtl/core/lmrs_front.sv
// Front end: accepts host words, gathers the staging frame, issues tick commands.
// Depends on lmrs_pkg and lmrs_if.
module lmrs_front import lmrs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	lmrs_in_if.sink     host,
	output logic        cmd_valid,
	output tick_cmd_t   cmd,
	input  logic        cmd_ready,
	input  logic        copy_done,
	output frame_t      staging
);

	frame_t           staging_q;
	logic [CNT_W-1:0] count_q;
	logic             pending_q;
	logic             copy_busy_q;
	logic [ROW_W-1:0] row_q;
	logic             take;

	// bytes wait while a copy command is still queued: staging must hold
	assign host.ready = (host.kind == KIND_TICK) ? cmd_ready : !copy_busy_q;
	assign take       = host.valid && host.ready;
	assign cmd_valid  = host.valid && (host.kind == KIND_TICK);
	assign cmd.row    = row_q;
	assign cmd.copy   = (row_q == '0) && pending_q;
	assign staging    = staging_q;

	always_ff @(posedge clk) begin
		if (take && host.kind == KIND_DATA && !pending_q) begin
			staging_q[count_q[COL_W-1:0]] <= host.column_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			pending_q   <= 1'b0;
			copy_busy_q <= 1'b0;
			row_q       <= '0;
		end else begin
			if (copy_done) begin
				copy_busy_q <= 1'b0;
			end
			if (take && host.kind == KIND_DATA && !pending_q) begin
				count_q <= count_q + CNT_W'(1);
				if (count_q == CNT_W'(COLUMNS - 1)) begin
					pending_q <= 1'b1;
				end
			end
			if (take && host.kind == KIND_TICK) begin
				if (cmd.copy) begin
					count_q     <= '0;
					pending_q   <= 1'b0;
					copy_busy_q <= 1'b1;
				end
				if (row_q == ROW_W'(ROWS - 1)) begin
					row_q <= '0;
				end else begin
					row_q <= row_q + ROW_W'(1);
				end
			end
		end
	end

endmodule

FILE: rtl/core/lmrs_cmd_fifo.sv
// Two-entry queue of tick commands between front and back.
// Depends on lmrs_pkg.
module lmrs_cmd_fifo import lmrs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push_valid,
	input  tick_cmd_t push_cmd,
	output logic      push_ready,
	output logic      pop_valid,
	output tick_cmd_t pop_cmd,
	input  logic      pop_ready
);

	tick_cmd_t            mem_q [CMD_DEPTH];
	logic [CMD_PTR_W-1:0] wr_q;
	logic [CMD_PTR_W-1:0] rd_q;
	logic [CMD_CNT_W-1:0] cnt_q;
	logic                 push;
	logic                 pop;

	assign push_ready = (cnt_q != CMD_CNT_W'(CMD_DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_cmd    = mem_q[rd_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_q + CMD_PTR_W'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_q + CMD_PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CMD_CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CMD_CNT_W'(1);
			end
		end
	end

endmodule

FILE: rtl/core/lmrs_back.sv
// Back end: holds the display frame and sequences the pin phases of each tick.
// Depends on lmrs_pkg and lmrs_if.
module lmrs_back import lmrs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	input  tick_cmd_t   cmd,
	output logic        cmd_ready,
	output logic        copy_done,
	input  frame_t      staging,
	lmrs_out_if.source  pins
);

	back_state_t      state_q, state_d;
	logic [PH_W-1:0]  phase_q, phase_d;
	logic [ROW_W-1:0] row_q;
	frame_t           display_q;
	logic             out_valid_q;
	pin_word_t        word_q, word_d;
	logic             adv;
	logic             load_word;
	logic             row0;
	logic [COL_W-1:0] col;
	logic [PH_W-1:0]  last_ph;

	assign row0      = (row_q == '0);
	assign last_ph   = row0 ? PH_LAST0 : PH_LASTN;
	assign col       = COL_W'(COLUMNS - 1) - phase_q[COL_W:1];
	assign adv       = !out_valid_q || pins.ready;
	assign copy_done = cmd_valid && cmd_ready && cmd.copy;

	always_comb begin
		word_d = '0;
		if (phase_q < PH_STROBE) begin
			word_d.shift_clock = phase_q[0];
			word_d.shift_data  = display_q[col][3'd7 - row_q];
		end else if (phase_q == PH_STROBE) begin
			word_d.row_reset   = row0;
			word_d.load_strobe = !row0;
		end else if (phase_q == PH_LASTN) begin
			word_d.row_reset   = row0;
			word_d.load_strobe = row0;
			word_d.last        = !row0;
		end else begin
			word_d.last        = 1'b1;
		end
	end

	always_comb begin
		state_d   = state_q;
		phase_d   = phase_q;
		cmd_ready = 1'b0;
		load_word = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid) begin
					state_d = BK_RUN;
					phase_d = '0;
				end
			end
			BK_RUN: begin
				if (adv) begin
					load_word = 1'b1;
					if (phase_q == last_ph) begin
						state_d = BK_IDLE;
					end else begin
						phase_d = phase_q + PH_W'(1);
					end
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			phase_q     <= '0;
			row_q       <= '0;
			display_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			if (cmd_valid && cmd_ready) begin
				row_q <= cmd.row;
				if (cmd.copy) begin
					display_q <= staging;
				end
			end
			if (adv) begin
				out_valid_q <= load_word;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_word) begin
			word_q <= word_d;
		end
	end

	assign pins.valid       = out_valid_q;
	assign pins.shift_clock = word_q.shift_clock;
	assign pins.shift_data  = word_q.shift_data;
	assign pins.load_strobe = word_q.load_strobe;
	assign pins.row_reset   = word_q.row_reset;
	assign pins.last        = word_q.last;

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_RUN |-> phase_q <= last_ph)
		else $error("phase counter ran past the end of the tick");

	a_clk_no_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(word_q.shift_clock && (word_q.load_strobe || word_q.row_reset)))
		else $error("shift clock overlaps a strobe");

	a_reset_row0: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && word_q.row_reset |-> row0)
		else $error("row reset outside row 0");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		load_word && word_d.last |=> state_q == BK_IDLE)
		else $error("last phase did not end the sequence");

endmodule

FILE: verif/led_matrix_row_scan_shifter_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for led_matrix_row_scan_shifter: drives host words and checks pin phases.
// Depends on lmrs_pkg and lmrs_if from rtl/core and on the block itself.
module led_matrix_row_scan_shifter_tb import lmrs_pkg::*; ;

	// Longest stretch with no word moving on either side. It is well above the
	// deliberate receiver hold (HOLD_CYCLES), so this leaves ample margin.
	localparam int IDLE_LIMIT   = 3000;
	localparam int HOLD_CYCLES  = 400;
	localparam int HOLD_AFTER   = 320;   // pin words seen before the long hold
	localparam int RANDOM_WORDS = 220;
	localparam int DRAIN_CYCLES = 40;    // one full tick sequence plus a bit
	localparam int REPORT_CAP   = 200;

	// Scan predictor and store of expected pin phases.
	class matrix_scan_scoreboard;
		logic [BYTE_W-1:0] shown_frame [COLUMNS];
		logic [BYTE_W-1:0] gathered_frame [COLUMNS];
		int unsigned       gathered_count;
		bit                frame_waiting;
		int unsigned       scan_row;
		pin_word_t         phase_queue [$];
		int unsigned       mismatches;

		function new();
			foreach (shown_frame[i]) shown_frame[i] = '0;
			foreach (gathered_frame[i]) gathered_frame[i] = '0;
			gathered_count = 0;
			frame_waiting  = 0;
			scan_row       = 0;
			mismatches     = 0;
		endfunction

		function pin_word_t phase(bit c, bit d, bit l, bit r, bit t);
			return {c, d, l, r, t};
		endfunction

		// Returns 1 when the word does something (tick, or byte that is stored).
		function bit note_word(logic kind, logic [BYTE_W-1:0] bits);
			bit b;
			if (kind == KIND_DATA) begin
				// bytes are dropped while a full frame waits for row 0
				if (frame_waiting || gathered_count >= COLUMNS)
					return 0;
				gathered_frame[gathered_count] = bits;
				gathered_count++;
				if (gathered_count >= COLUMNS)
					frame_waiting = 1;
				return 1;
			end
			// frame copy only at the start of a row 0 tick
			if (scan_row == 0 && frame_waiting) begin
				shown_frame    = gathered_frame;
				gathered_count = 0;
				frame_waiting  = 0;
			end
			for (int col = COLUMNS - 1; col >= 0; col--) begin
				b = shown_frame[col][7 - scan_row];
				phase_queue.push_back(phase(1'b0, b, 1'b0, 1'b0, 1'b0));
				phase_queue.push_back(phase(1'b1, b, 1'b0, 1'b0, 1'b0));
			end
			if (scan_row == 0) begin
				phase_queue.push_back(phase(1'b0, 1'b0, 1'b0, 1'b1, 1'b0));
				phase_queue.push_back(phase(1'b0, 1'b0, 1'b1, 1'b1, 1'b0));
			end else begin
				phase_queue.push_back(phase(1'b0, 1'b0, 1'b1, 1'b0, 1'b0));
			end
			phase_queue.push_back(phase(1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
			scan_row = (scan_row + 1 >= ROWS) ? 0 : scan_row + 1;
			return 1;
		endfunction

		function void check_phase(pin_word_t got);
			string     field_name [5] = '{"shift_clock", "shift_data", "load_strobe",
				"row_reset", "last"};
			pin_word_t want;
			logic [4:0] w;
			logic [4:0] a;
			if (phase_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_CAP)
					$error("pin word %b arrived with no phase expected", got);
				return;
			end
			want = phase_queue.pop_front();
			w = want;
			a = got;
			for (int i = 0; i < 5; i++) begin
				if (w[4-i] !== a[4-i]) begin
					mismatches++;
					// keep the log readable on a badly broken build
					if (mismatches <= REPORT_CAP)
						$error("%s: expected %0b, got %0b", field_name[i], w[4-i], a[4-i]);
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	lmrs_in_if  host_ch ();
	lmrs_out_if pin_ch ();

	led_matrix_row_scan_shifter dut (
		.clk    (clk),
		.arst_n (arst_n),
		.host   (host_ch),
		.pins   (pin_ch)
	);

	matrix_scan_scoreboard board = new();

	int unsigned burst_left;
	int unsigned useful_words;
	int unsigned phases_seen = 0;
	int unsigned idle_cycles;

	always #10 clk = ~clk;

	// Column byte: mostly uniform, sometimes an edge pattern.
	function automatic logic [BYTE_W-1:0] rand_column();
		logic [BYTE_W-1:0] edge_set [6] = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'h55, 8'hAA};
		if ($urandom_range(0, 9) < 7)
			return BYTE_W'($urandom);
		return edge_set[$urandom_range(0, 5)];
	endfunction

	// Offer one host word and wait for it to be taken. The sender runs in
	// bursts; between bursts valid drops for a random gap, sometimes none.
	task automatic send_word(logic kind, logic [BYTE_W-1:0] bits);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				host_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		host_ch.valid       <= 1'b1;
		host_ch.kind        <= kind;
		host_ch.column_byte <= bits;
		do @(posedge clk); while (host_ch.ready !== 1'b1);
		if (board.note_word(kind, bits))
			useful_words++;
	endtask

	// Directed opening: blank tick on row 0, a full frame of edge patterns,
	// a byte dropped while the frame waits, then ticks round to row 0 where
	// the frame is copied and shown.
	task automatic run_directed();
		logic [BYTE_W-1:0] patterns [COLUMNS] = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'h02,
			8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h7F, 8'hFE, 8'h55, 8'hAA, 8'hC3, 8'h3C};
		send_word(KIND_TICK, 8'hA5);
		foreach (patterns[i])
			send_word(KIND_DATA, patterns[i]);
		send_word(KIND_DATA, 8'hFF);
		repeat (ROWS) send_word(KIND_TICK, 8'h5A);
	endtask

	// Random part: mostly whole frames with ticks sprinkled in (partial
	// frames across ticks, bytes dropped while a frame waits), some runs of
	// ticks, and some noise.
	task automatic run_random();
		int unsigned pick;
		while (useful_words < RANDOM_WORDS) begin
			pick = $urandom_range(0, 9);
			if (pick < 6) begin
				for (int c = 0; c < COLUMNS; c++) begin
					if ($urandom_range(0, 7) == 0)
						send_word(KIND_TICK, BYTE_W'($urandom));
					send_word(KIND_DATA, rand_column());
				end
				repeat ($urandom_range(1, ROWS + 1)) send_word(KIND_TICK, BYTE_W'($urandom));
			end else if (pick < 8) begin
				repeat ($urandom_range(1, 4)) send_word(KIND_TICK, BYTE_W'($urandom));
			end else begin
				repeat ($urandom_range(1, 6))
					send_word(1'($urandom_range(0, 1)), BYTE_W'($urandom));
			end
		end
	endtask

	// Main sequence: reset once, stimulus, drain, verdict.
	initial begin
		arst_n              <= 1'b0;
		host_ch.valid       <= 1'b0;
		host_ch.kind        <= KIND_DATA;
		host_ch.column_byte <= '0;
		burst_left   = 0;
		useful_words = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		run_random();
		host_ch.valid <= 1'b0;
		// watchdog catches a drain that never completes
		while (board.phase_queue.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// Receiver: stalls follow one of four randomly redrawn modes; once, after enough
	// pin words, it holds off long enough for ticks to queue up and the host
	// side to stall.
	initial begin
		int unsigned cyc;
		int unsigned mode;
		int unsigned stall_left;
		bit          hold_done;
		bit          r;
		pin_ch.ready <= 1'b0;
		cyc        = 0;
		mode       = 0;
		stall_left = 0;
		hold_done  = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (!hold_done && phases_seen >= HOLD_AFTER) begin
				hold_done = 1;
				pin_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			cyc++;
			if (cyc % 50 == 0)
				mode = $urandom_range(0, 3);
			if (stall_left > 0) begin
				stall_left--;
				r = 1'b0;
			end else begin
				case (mode)
					0: r = 1'b1;
					1: r = ($urandom_range(0, 3) != 0);
					2: r = cyc[0];
					default: begin
						r = 1'b1;
						if ($urandom_range(0, 15) == 0)
							stall_left = $urandom_range(2, 8);
					end
				endcase
			end
			pin_ch.ready <= r;
		end
	end

	// Pin side monitor: a pin word moves when valid and ready were both high.
	always @(posedge clk) begin
		if (arst_n && pin_ch.valid === 1'b1 && pin_ch.ready === 1'b1) begin
			phases_seen <= phases_seen + 1;
			board.check_phase({pin_ch.shift_clock, pin_ch.shift_data,
				pin_ch.load_strobe, pin_ch.row_reset, pin_ch.last});
		end
	end

	// Watchdog: cycles in which no word moves on either side.
	always @(posedge clk) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((host_ch.valid === 1'b1 && host_ch.ready === 1'b1) ||
				(pin_ch.valid === 1'b1 && pin_ch.ready === 1'b1)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule

FILE: filelist.f
rtl/core/lmrs_pkg.sv
rtl/core/lmrs_if.sv
rtl/core/lmrs_front.sv
rtl/core/lmrs_cmd_fifo.sv
rtl/core/lmrs_back.sv
rtl/core/led_matrix_row_scan_shifter.sv
verif/led_matrix_row_scan_shifter_tb.sv
